@@ rtl/mvt_pkg.sv @@
// ----------------------------------------------------------------------------
// mvt_pkg: shared types and constants for the matrix-vector transform
// Operation codes and fixed widths used by the transform datapath.
// ----------------------------------------------------------------------------
package mvt_pkg;

	localparam int unsigned WORD_W = 32;  // Q format word
	localparam int unsigned LANES  = 4;   // vector components / matrix rows
	localparam int unsigned PROD_W = 2 * WORD_W;
	localparam int unsigned SUM_W  = PROD_W + 2;  // four products, exact

	typedef logic [1:0] op_t;

	localparam op_t OP_WRITE = 2'd0;
	localparam op_t OP_POINT = 2'd1;
	localparam op_t OP_DIR   = 2'd2;
	localparam op_t OP_VEC4  = 2'd3;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

endpackage

@@ rtl/matrix_vector_transform.sv @@
// ----------------------------------------------------------------------------
// matrix_vector_transform: 4x4 fixed-point matrix times vector
// Holds a column-major 4x4 matrix and streams vectors through it.
// ----------------------------------------------------------------------------
// The block keeps sixteen signed fixed-point matrix words (word 4*col+row,
// all zero after reset), taking one input word per clock when ready. A write-element
// word stores elem_value at elem_index in the cycle it is accepted and gives
// no result; it affects every transform accepted after it and none before.
// Transform point multiplies x,y,z by the 3x3 part and adds the translation
// column, transform direction uses the 3x3 part alone, and transform vec4
// uses all sixteen words with in_w. Each component is the exact sum of
// products, floored to FRAC_BITS fraction bits, then clipped to 32 bits;
// saturated flags any clipped component, and out_w is zero unless vec4.
// Throughput is one word per cycle while in_ready is high. There are
// three register stages: 16 parallel 32x32 multipliers, a per-row adder
// tree, then floor, translation add and clip into the output register.
// A full stage holds when the one after it is full and stalled, so empty
// stages still fill while a result waits.
module matrix_vector_transform
	import mvt_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               op,
	input  logic [3:0]               elem_index,
	input  logic signed [WORD_W-1:0] elem_value,
	input  logic signed [WORD_W-1:0] in_x,
	input  logic signed [WORD_W-1:0] in_y,
	input  logic signed [WORD_W-1:0] in_z,
	input  logic signed [WORD_W-1:0] in_w,

	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [WORD_W-1:0] out_x,
	output logic signed [WORD_W-1:0] out_y,
	output logic signed [WORD_W-1:0] out_z,
	output logic signed [WORD_W-1:0] out_w,
	output logic                     saturated
);

	// width after the fraction is dropped and the translation added
	localparam int unsigned RES_W = SUM_W - FRAC_BITS + 1;

	// matrix store, column major
	word_t mat_q [LANES*LANES];

	// stage valids and per-stage ready
	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;
	logic in_fire;

	// input side
	word_t vin_c   [LANES];
	prod_t prod_c  [LANES][LANES];
	word_t trans_c [LANES];

	// stage 1: products
	prod_t prod_s1  [LANES][LANES];
	word_t trans_s1 [LANES];
	logic  vec4_s1;

	// stage 2: row sums
	sum_t  sum_c    [LANES];
	sum_t  sum_s2   [LANES];
	word_t trans_s2 [LANES];
	logic  vec4_s2;

	// stage 3: clipped result
	sum_t                    shr_c [LANES];
	logic signed [RES_W-1:0] res_c [LANES];
	word_t                   clip_c [LANES];
	logic  [LANES-1:0]       sat_c;
	word_t                   res_s3 [LANES];
	logic                    sat_s3;

	// ---------------------------------------------------------------- handshake
	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign in_fire  = in_valid && in_ready;

	// ---------------------------------------------------------------- matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LANES*LANES; k++) begin
				mat_q[k] <= '0;
			end
		end else if (in_fire && op == OP_WRITE) begin
			mat_q[elem_index] <= elem_value;
		end
	end

	// ---------------------------------------------------------------- multiply
	// w only takes part in vec4; translation only in point
	always_comb begin
		vin_c[0] = in_x;
		vin_c[1] = in_y;
		vin_c[2] = in_z;
		vin_c[3] = (op == OP_VEC4) ? in_w : '0;
		for (int j = 0; j < LANES; j++) begin
			for (int i = 0; i < LANES; i++) begin
				prod_c[j][i] = vin_c[i] * mat_q[LANES*i+j];
			end
			trans_c[j] = (op == OP_POINT) ? mat_q[LANES*(LANES-1)+j] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_fire && op != OP_WRITE;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			prod_s1  <= prod_c;
			trans_s1 <= trans_c;
			vec4_s1  <= (op == OP_VEC4);
		end
	end

	// ---------------------------------------------------------------- row sums
	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			sum_c[j] = (SUM_W'(prod_s1[j][0]) + SUM_W'(prod_s1[j][1]))
			         + (SUM_W'(prod_s1[j][2]) + SUM_W'(prod_s1[j][3]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			sum_s2   <= sum_c;
			trans_s2 <= trans_s1;
			vec4_s2  <= vec4_s1;
		end
	end

	// ---------------------------------------------------------------- floor, add, clip
	// arithmetic shift floors toward minus infinity
	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			shr_c[j] = sum_s2[j] >>> FRAC_BITS;
			res_c[j] = RES_W'(shr_c[j]) + RES_W'(trans_s2[j]);
			if (!res_c[j][RES_W-1] && (|res_c[j][RES_W-2:WORD_W-1])) begin
				clip_c[j] = {1'b0, {(WORD_W-1){1'b1}}};
				sat_c[j]  = 1'b1;
			end else if (res_c[j][RES_W-1] && !(&res_c[j][RES_W-2:WORD_W-1])) begin
				clip_c[j] = {1'b1, {(WORD_W-1){1'b0}}};
				sat_c[j]  = 1'b1;
			end else begin
				clip_c[j] = res_c[j][WORD_W-1:0];
				sat_c[j]  = 1'b0;
			end
		end
		// w lane only counts for vec4
		if (!vec4_s2) begin
			clip_c[LANES-1] = '0;
			sat_c[LANES-1]  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			res_s3 <= clip_c;
			sat_s3 <= |sat_c;
		end
	end

	// ---------------------------------------------------------------- outputs
	assign out_valid = v_s3;
	assign out_x     = res_s3[0];
	assign out_y     = res_s3[1];
	assign out_z     = res_s3[2];
	assign out_w     = res_s3[3];
	assign saturated = sat_s3;

endmodule
